### src/qdd_pkg.sv
// shared types, register codes and the transition table of the quadrature detent decoder
package qdd_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int OUT_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_STEPS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HYST  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] STEPS_RESET = 7'd4;
  localparam logic [CFG_DATA_W-1:0] HYST_RESET  = 7'd0;
  localparam logic [CFG_DATA_W-1:0] STEPS_MIN   = 7'd1;
  localparam logic [CFG_DATA_W-1:0] STEP_LIMIT  = 7'd127;

  localparam logic [1:0] CHANNELS_DETENT = 2'b11;

  // index is {previous channels, current channels}
  localparam logic signed [1:0] MOVE_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef enum logic [1:0] {
    BIAS_NONE = 2'd0,
    BIAS_POS  = 2'd1,
    BIAS_NEG  = 2'd2
  } bias_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_NEG,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic              restart;
    logic signed [1:0] move;
    logic              detent;
    logic              btn_edge;
    logic              btn_level;
    logic              take_delta;
    logic              take_pressed;
    logic              take_released;
  } cmd_t;

endpackage

### src/qdd_front.sv
// front end: accepts samples, tracks the last pin levels and classifies each sample
module qdd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          channel_a,
  input  logic          channel_b,
  input  logic          button_level,
  input  logic          restart,
  input  logic          take_delta,
  input  logic          take_pressed,
  input  logic          take_released,
  input  logic          q_full,
  output logic          q_push,
  output qdd_pkg::cmd_t q_cmd
);

  logic [1:0] last_channels;
  logic       last_button_level;
  logic [1:0] chans;
  logic       changed;
  logic       accept;

  assign chans    = {channel_a, channel_b};
  assign changed  = (chans != last_channels);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    q_cmd.restart       = restart;
    q_cmd.move          = (restart || !changed) ? 2'sd0 : qdd_pkg::MOVE_TABLE[{last_channels, chans}];
    q_cmd.detent        = !restart && changed && (chans == qdd_pkg::CHANNELS_DETENT);
    q_cmd.btn_edge      = !restart && (button_level != last_button_level);
    q_cmd.btn_level     = button_level;
    q_cmd.take_delta    = take_delta;
    q_cmd.take_pressed  = take_pressed;
    q_cmd.take_released = take_released;
  end

  // restart and ordinary samples both leave this sample as the new reference
  always_ff @(posedge clk) begin
    if (rst) begin
      last_channels     <= qdd_pkg::CHANNELS_DETENT;
      last_button_level <= 1'b1;
    end else if (accept) begin
      last_channels     <= chans;
      last_button_level <= button_level;
    end
  end

endmodule

### src/qdd_queue.sv
// two-entry command queue between the front end and the step engine
module qdd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qdd_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output qdd_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  qdd_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/qdd_back.sv
// step engine: accumulates movement, converts it to steps one per cycle, keeps counts and events
module qdd_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [qdd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qdd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_valid,
  input  qdd_pkg::cmd_t                       q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COUNT_WIDTH-1:0]              out_position,
  output logic [COUNT_WIDTH-1:0]              out_delta,
  output logic                                out_button_down,
  output logic                                out_press,
  output logic                                out_release
);

  qdd_pkg::back_state_t state, state_next;
  qdd_pkg::bias_t       bias, bias_next;

  logic [qdd_pkg::CFG_DATA_W-1:0] steps;
  logic [qdd_pkg::CFG_DATA_W-1:0] hyst;
  logic [qdd_pkg::CFG_DATA_W-1:0] hyst_max;

  logic signed [7:0]      acc, acc_next;
  logic [COUNT_WIDTH-1:0] pos, pos_next;
  logic [COUNT_WIDTH-1:0] dlt, dlt_next;
  logic                   btn_state, btn_state_next;
  logic                   press, press_next;
  logic                   rel, rel_next;
  logic [2:0]             takes, takes_next;
  logic                   out_load;
  logic                   out_free;

  logic signed [8:0]      sum9;
  logic signed [7:0]      acc_sat;
  logic [8:0]             th;
  logic signed [9:0]      acc_ext;
  logic signed [9:0]      th_ext;
  logic signed [9:0]      acc_sub;
  logic signed [9:0]      acc_add;

  assign out_free = !out_valid || out_ready;
  assign hyst_max = qdd_pkg::STEP_LIMIT - steps;

  // saturating add of the transition value
  assign sum9 = {acc[7], acc} + {{7{q_cmd.move[1]}}, q_cmd.move};
  always_comb begin
    if (sum9 > 9'sd127) begin
      acc_sat = 8'sd127;
    end else if (sum9 < -9'sd128) begin
      acc_sat = -8'sd128;
    end else begin
      acc_sat = sum9[7:0];
    end
  end

  // reversal needs the hysteresis on top of the step threshold
  always_comb begin
    th = {2'b00, steps};
    if ((state == qdd_pkg::ST_POS && bias == qdd_pkg::BIAS_NEG) ||
        (state == qdd_pkg::ST_NEG && bias == qdd_pkg::BIAS_POS)) begin
      th = {2'b00, steps} + {2'b00, hyst};
    end
  end

  assign acc_ext = {{2{acc[7]}}, acc};
  assign th_ext  = {1'b0, th};
  assign acc_sub = acc_ext - th_ext;
  assign acc_add = acc_ext + th_ext;

  always_comb begin
    state_next     = state;
    bias_next      = bias;
    acc_next       = acc;
    pos_next       = pos;
    dlt_next       = dlt;
    btn_state_next = btn_state;
    press_next     = press;
    rel_next       = rel;
    takes_next     = takes;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      qdd_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          takes_next = {q_cmd.take_delta, q_cmd.take_pressed, q_cmd.take_released};
          if (q_cmd.restart) begin
            pos_next       = '0;
            dlt_next       = '0;
            press_next     = 1'b0;
            rel_next       = 1'b0;
            acc_next       = 8'sd0;
            bias_next      = qdd_pkg::BIAS_NONE;
            btn_state_next = !q_cmd.btn_level;
            state_next     = qdd_pkg::ST_DONE;
          end else begin
            acc_next = acc_sat;
            if (q_cmd.btn_edge) begin
              btn_state_next = !q_cmd.btn_level;
              if (!q_cmd.btn_level) begin
                press_next = 1'b1;
              end else begin
                rel_next = 1'b1;
              end
            end
            state_next = q_cmd.detent ? qdd_pkg::ST_POS : qdd_pkg::ST_DONE;
          end
        end
      end
      qdd_pkg::ST_POS: begin
        if (acc_ext >= th_ext) begin
          pos_next  = pos + COUNT_WIDTH'(1);
          dlt_next  = dlt + COUNT_WIDTH'(1);
          acc_next  = acc_sub[7:0];
          bias_next = qdd_pkg::BIAS_POS;
        end else begin
          state_next = qdd_pkg::ST_NEG;
        end
      end
      qdd_pkg::ST_NEG: begin
        if (acc_add <= 10'sd0) begin
          pos_next  = pos - COUNT_WIDTH'(1);
          dlt_next  = dlt - COUNT_WIDTH'(1);
          acc_next  = acc_add[7:0];
          bias_next = qdd_pkg::BIAS_NEG;
        end else begin
          state_next = qdd_pkg::ST_DONE;
        end
      end
      qdd_pkg::ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = qdd_pkg::ST_IDLE;
          if (takes[2]) begin
            dlt_next = '0;
          end
          if (takes[1]) begin
            press_next = 1'b0;
          end
          if (takes[0]) begin
            rel_next = 1'b0;
          end
        end
      end
      default: state_next = qdd_pkg::ST_IDLE;
    endcase
    // a hysteresis write restarts the accumulation
    if (cfg_write && cfg_index == qdd_pkg::REG_HYST) begin
      acc_next  = 8'sd0;
      bias_next = qdd_pkg::BIAS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qdd_pkg::ST_IDLE;
      bias      <= qdd_pkg::BIAS_NONE;
      acc       <= 8'sd0;
      pos       <= '0;
      dlt       <= '0;
      btn_state <= 1'b0;
      press     <= 1'b0;
      rel       <= 1'b0;
      takes     <= 3'b000;
    end else begin
      state     <= state_next;
      bias      <= bias_next;
      acc       <= acc_next;
      pos       <= pos_next;
      dlt       <= dlt_next;
      btn_state <= btn_state_next;
      press     <= press_next;
      rel       <= rel_next;
      takes     <= takes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= qdd_pkg::STEPS_RESET;
      hyst  <= qdd_pkg::HYST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        qdd_pkg::REG_STEPS: steps <= (cfg_data == '0) ? qdd_pkg::STEPS_MIN : cfg_data;
        qdd_pkg::REG_HYST:  hyst  <= (cfg_data <= hyst_max) ? cfg_data : hyst_max;
        default: ;
      endcase
    end
  end

  // result register, reports counts and events before the takes clear them
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_position    <= pos;
      out_delta       <= dlt;
      out_button_down <= btn_state;
      out_press       <= press;
      out_release     <= rel;
    end
  end

endmodule

### src/quadrature_detent_decoder_top.sv
// top level of the quadrature detent decoder: front end, command queue and step engine
//
// One sample of the encoder channels and the button goes in per transaction and one result
// comes out per transaction. A sample off the detent position goes from ST_IDLE to ST_DONE;
// a detent sample also passes ST_POS and ST_NEG, one step per cycle, as the step engine
// subtracts or adds the threshold (up to 32 steps from a saved-up sum with the default of four
// transitions per step, up to 128 with one). The front end keeps accepting into a two-entry
// queue while the step engine works, until it is full. A finished result waits in its output
// register; the next sample is stepped meanwhile, its result waiting in ST_DONE until that
// one is taken. Counts are COUNT_WIDTH bits wide and wrap, sign-extended or truncated to 32 output bits.
module quadrature_detent_decoder_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [qdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [qdd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             channel_a,
  input  logic                             channel_b,
  input  logic                             button_level,
  input  logic                             restart,
  input  logic                             take_delta,
  input  logic                             take_pressed,
  input  logic                             take_released,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [qdd_pkg::OUT_W-1:0] position,
  output logic signed [qdd_pkg::OUT_W-1:0] delta,
  output logic                             button_down,
  output logic                             press_event,
  output logic                             release_event
);

  qdd_pkg::cmd_t          push_cmd;
  qdd_pkg::cmd_t          pop_cmd;
  logic                   q_push;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [COUNT_WIDTH-1:0] pos_w;
  logic [COUNT_WIDTH-1:0] dlt_w;

  qdd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .channel_a     (channel_a),
    .channel_b     (channel_b),
    .button_level  (button_level),
    .restart       (restart),
    .take_delta    (take_delta),
    .take_pressed  (take_pressed),
    .take_released (take_released),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  qdd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd),
    .pop      (q_pop)
  );

  qdd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (pos_w),
    .out_delta       (dlt_w),
    .out_button_down (button_down),
    .out_press       (press_event),
    .out_release     (release_event)
  );

  generate
    if (COUNT_WIDTH >= qdd_pkg::OUT_W) begin : g_trunc
      assign position = pos_w[qdd_pkg::OUT_W-1:0];
      assign delta    = dlt_w[qdd_pkg::OUT_W-1:0];
    end else begin : g_sext
      assign position = {{(qdd_pkg::OUT_W-COUNT_WIDTH){pos_w[COUNT_WIDTH-1]}}, pos_w};
      assign delta    = {{(qdd_pkg::OUT_W-COUNT_WIDTH){dlt_w[COUNT_WIDTH-1]}}, dlt_w};
    end
  endgenerate

  // the step engine only pops a command that is there
  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("step engine popped an empty queue");

  // reset leaves an empty queue and no pending result
  a_reset_clean: assert property (@(posedge clk) rst |=> (in_ready && !out_valid && !q_valid))
    else $error("state not clean after reset");

  // a full queue holds off new samples
  a_full_blocks: assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("sample pushed into a full queue");

endmodule
